// ----- design/pfl_pkg.sv -----
package pfl_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY = 2'd0,
        CFG_FRAMES = 2'd1
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 5'd3;

    // Replacement policies
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Fixed result field widths
    localparam int COUNT_OUT_W = 16;
    localparam int SLOT_OUT_W  = 4;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Search record flags handed from cell to cell
    typedef struct packed {
        logic tok;    // search token is at this stage
        logic hit;    // a matching frame was found
        logic empty;  // a free frame was found (no hit)
    } t_scan_flags;

    // Update command broadcast to every cell
    typedef struct packed {
        logic en;     // apply the update for the current word
        logic load;   // page fault: write tag into the chosen slot
        logic clear;  // new sequence: drop every frame
    } t_upd_ctl;

endpackage

// ----- design/pfl_cell.sv -----
module pfl_cell
    import pfl_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 24,
    parameter int IDX        = 0
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]              i_n,
    input  logic [PAGE_BITS-1:0]                         i_page,
    input  t_upd_ctl                                     i_upd,
    input  logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] i_upd_slot,
    input  logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] i_upd_old_rank,
    input  t_scan_flags                                  i_flags,
    input  logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] i_cand_idx,
    input  logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] i_cand_rank,
    input  logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] i_lru_idx,
    input  logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] i_lru_rank,
    output t_scan_flags                                  o_flags,
    output logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] o_cand_idx,
    output logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] o_cand_rank,
    output logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] o_lru_idx,
    output logic [((MAX_FRAMES>1)?$clog2(MAX_FRAMES):1)-1:0] o_lru_rank
);

    localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam logic [SW-1:0] MY_IDX   = SW'(IDX);
    localparam logic [SW-1:0] RANK_MAX = SW'(MAX_FRAMES - 1);

    logic [PAGE_BITS-1:0] r_tag;
    logic                 r_valid;
    logic [SW-1:0]        r_rank;

    t_scan_flags          r_flags;
    logic [SW-1:0]        r_cand_idx;
    logic [SW-1:0]        r_cand_rank;
    logic [SW-1:0]        r_lru_idx;
    logic [SW-1:0]        r_lru_rank;

    t_scan_flags          n_flags;
    logic [SW-1:0]        n_cand_idx;
    logic [SW-1:0]        n_cand_rank;
    logic [SW-1:0]        n_lru_idx;
    logic [SW-1:0]        n_lru_rank;

    logic                 w_active;
    logic                 w_match;
    logic                 w_mine;

    assign w_active = NW'(IDX) < i_n;
    assign w_match  = r_valid && (r_tag == i_page);
    assign w_mine   = i_upd_slot == MY_IDX;

    // Fold this frame into the search record coming from the left
    always_comb begin
        n_flags     = i_flags;
        n_cand_idx  = i_cand_idx;
        n_cand_rank = i_cand_rank;
        n_lru_idx   = i_lru_idx;
        n_lru_rank  = i_lru_rank;
        if (w_active) begin
            if (!i_flags.hit && w_match) begin
                n_flags.hit   = 1'b1;
                n_flags.empty = 1'b0;
                n_cand_idx    = MY_IDX;
                n_cand_rank   = r_rank;
            end else if (!i_flags.hit && !i_flags.empty && !r_valid) begin
                n_flags.empty = 1'b1;
                n_cand_idx    = MY_IDX;
            end
            // strict compare keeps the lowest index among equal ranks
            if (r_rank > i_lru_rank) begin
                n_lru_idx  = MY_IDX;
                n_lru_rank = r_rank;
            end
        end
    end

    // Search record stage: only the token is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.tok <= 1'b0;
        end else begin
            r_flags.tok <= i_flags.tok;
        end
        if (i_flags.tok) begin
            r_flags.hit   <= n_flags.hit;
            r_flags.empty <= n_flags.empty;
            r_cand_idx    <= n_cand_idx;
            r_cand_rank   <= n_cand_rank;
            r_lru_idx     <= n_lru_idx;
            r_lru_rank    <= n_lru_rank;
        end
    end

    // Frame state: valid and recency rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.clear) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (w_mine) begin
                if (i_upd.load) begin
                    r_valid <= 1'b1;
                end
                r_rank <= '0;
            end else if (r_valid && (i_upd.load || r_rank < i_upd_old_rank) &&
                         r_rank < RANK_MAX) begin
                // a newly loaded page is newer than every resident one
                r_rank <= r_rank + SW'(1);
            end
        end
    end

    // Tag store
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.load && w_mine) begin
            r_tag <= i_page;
        end
    end

    assign o_flags     = r_flags;
    assign o_cand_idx  = r_cand_idx;
    assign o_cand_rank = r_cand_rank;
    assign o_lru_idx   = r_lru_idx;
    assign o_lru_rank  = r_lru_rank;

endmodule

// ----- design/page_replacement_fifo_lru.sv -----
// Channel    Handshake          Payload
// request    start / busy       i_page_number, i_sequence_start
// result     o_strobe           o_fault, o_fault_count, o_frame_slot
// config     i_cfg_we           i_cfg_idx, i_cfg_data
//
// A word accepted at one edge is searched by a token that walks one frame
// cell per cycle; the result strobe is registered after the token leaves
// the last cell, and no new word is accepted while a search is in flight.
// busy is high from the accept edge until the result cycle; a new word may be
// accepted in the cycle the result is shown. Synchronous active-low reset
// empties every frame, sets FIFO mode and three frames. The receiver cannot
// stall; the result is valid for exactly the strobe cycle.
module page_replacement_fifo_lru
    import pfl_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_BITS-1:0]   i_page_number,
    input  logic                   i_sequence_start,
    output logic                   o_strobe,
    output logic                   o_fault,
    output logic [COUNT_OUT_W-1:0] o_fault_count,
    output logic [SLOT_OUT_W-1:0]  o_frame_slot,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);

    // Configuration
    logic                  r_policy;
    logic [CFG_DATA_W-1:0] r_frames;
    logic [NW-1:0]         w_n;

    // Control
    t_state                r_state;
    t_state                n_state;
    logic                  r_launch;
    logic [PAGE_BITS-1:0]  r_page;
    logic [SW-1:0]         r_ptr;
    logic [COUNT_BITS-1:0] r_count;
    logic                  w_accept;
    logic                  w_done;

    // Decision
    logic [SW-1:0]         w_slot;
    logic                  w_hit;
    logic [SW-1:0]         w_ptr_use;
    logic [NW-1:0]         w_slot_inc;
    t_upd_ctl              w_upd;

    // Cell chain
    t_scan_flags           w_flags    [0:MAX_FRAMES];
    logic [SW-1:0]         w_cand_idx [0:MAX_FRAMES];
    logic [SW-1:0]         w_cand_rank[0:MAX_FRAMES];
    logic [SW-1:0]         w_lru_idx  [0:MAX_FRAMES];
    logic [SW-1:0]         w_lru_rank [0:MAX_FRAMES];
    logic [MAX_FRAMES-1:0] w_tok_vec;

    assign w_accept = start && !busy;
    assign busy     = r_state == ST_SCAN;
    assign w_done   = (r_state == ST_SCAN) && w_flags[MAX_FRAMES].tok;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_FIFO;
            r_frames <= FRAMES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_FRAMES: r_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Active frame count, clamped to 1..MAX_FRAMES
    always_comb begin
        if (r_frames == '0) begin
            w_n = NW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_n = NW'(MAX_FRAMES);
        end else begin
            w_n = NW'(r_frames);
        end
    end

    // State machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_SCAN;
            ST_SCAN: if (w_done)   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_page_number;
        end
    end

    // Slot choice (hit, free frame or victim) once the token leaves the last cell
    always_comb begin
        w_hit      = w_flags[MAX_FRAMES].hit;
        w_ptr_use  = (NW'(r_ptr) < w_n) ? r_ptr : '0;
        if (w_hit || w_flags[MAX_FRAMES].empty) begin
            w_slot = w_cand_idx[MAX_FRAMES];
        end else if (r_policy == POLICY_FIFO) begin
            w_slot = w_ptr_use;
        end else begin
            w_slot = w_lru_idx[MAX_FRAMES];
        end
        w_slot_inc = NW'(w_slot) + NW'(1);
        w_upd.en    = w_done;
        w_upd.load  = w_done && !w_hit;
        w_upd.clear = w_accept && i_sequence_start;
    end

    // FIFO pointer and fault count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
        end else if (w_upd.clear) begin
            r_ptr   <= '0;
            r_count <= '0;
        end else if (w_done && !w_hit) begin
            if (r_policy == POLICY_FIFO) begin
                r_ptr <= (w_slot_inc >= w_n) ? '0 : SW'(w_slot_inc);
            end
            if (r_count != '1) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            o_fault       <= !w_hit;
            o_fault_count <= COUNT_OUT_W'((!w_hit && r_count != '1) ?
                                          r_count + COUNT_BITS'(1) : r_count);
            o_frame_slot  <= SLOT_OUT_W'(w_slot);
        end
    end

    // Head of the chain
    assign w_flags[0]     = '{tok: r_launch, hit: 1'b0, empty: 1'b0};
    assign w_cand_idx[0]  = '0;
    assign w_cand_rank[0] = '0;
    assign w_lru_idx[0]   = '0;
    assign w_lru_rank[0]  = '0;

    // One cell per frame
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        pfl_cell #(
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_n            (w_n),
            .i_page         (r_page),
            .i_upd          (w_upd),
            .i_upd_slot     (w_slot),
            .i_upd_old_rank (w_cand_rank[MAX_FRAMES]),
            .i_flags        (w_flags[g]),
            .i_cand_idx     (w_cand_idx[g]),
            .i_cand_rank    (w_cand_rank[g]),
            .i_lru_idx      (w_lru_idx[g]),
            .i_lru_rank     (w_lru_rank[g]),
            .o_flags        (w_flags[g+1]),
            .o_cand_idx     (w_cand_idx[g+1]),
            .o_cand_rank    (w_cand_rank[g+1]),
            .o_lru_idx      (w_lru_idx[g+1]),
            .o_lru_rank     (w_lru_rank[g+1])
        );
        assign w_tok_vec[g] = w_flags[g+1].tok;
    end

`ifndef SYNTHESIS
    // Only one search token in flight
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one search token in the cell chain");

    // Token leaving the chain finishes the word and strobes next cycle
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (o_strobe && !busy))
        else $error("result strobe missing after search end");

    // No token while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !r_launch |-> (w_tok_vec == '0))
        else $error("search token present while idle");
`endif

endmodule
